// ===== hw/rtl/rpfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfd_pkg: shared types and constants for the RTS pulse frame decoder
// Payload words, configuration set, pulse classes and frame check result.
// ----------------------------------------------------------------------------
package rpfd_pkg;

  localparam int unsigned PulseW     = 16;
  localparam int unsigned NumBytes   = 10;
  localparam int unsigned FrameW     = NumBytes * 8;
  localparam int unsigned BitCntW    = 7;
  localparam int unsigned SyncCntW   = 5;
  localparam int unsigned ShortBits  = 56;
  localparam int unsigned LongBits   = 80;
  localparam int unsigned MinHwSyncs = 4;
  localparam int unsigned NumCfgRegs = 8;
  localparam int unsigned CfgIdxW    = $clog2(NumCfgRegs);

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_HW_SYNC_MIN  = 3'd0,
    CFG_HW_SYNC_MAX  = 3'd1,
    CFG_SW_SYNC_MIN  = 3'd2,
    CFG_SW_SYNC_MAX  = 3'd3,
    CFG_HALF_SYM_MIN = 3'd4,
    CFG_HALF_SYM_MAX = 3'd5,
    CFG_FULL_SYM_MIN = 3'd6,
    CFG_FULL_SYM_MAX = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [PulseW-1:0] pulse_width;
    logic              capture_end;
  } in_word_t;

  typedef struct packed {
    logic        frame_found;
    logic [3:0]  command_code;
    logic [15:0] rolling_count;
    logic [23:0] remote_address;
  } out_word_t;

  typedef struct packed {
    logic [PulseW-1:0] hw_sync_min;
    logic [PulseW-1:0] hw_sync_max;
    logic [PulseW-1:0] sw_sync_min;
    logic [PulseW-1:0] sw_sync_max;
    logic [PulseW-1:0] half_symbol_min;
    logic [PulseW-1:0] half_symbol_max;
    logic [PulseW-1:0] full_symbol_min;
    logic [PulseW-1:0] full_symbol_max;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    hw_sync_min:     16'd1792,
    hw_sync_max:     16'd3328,
    sw_sync_min:     16'd3395,
    sw_sync_max:     16'd6305,
    half_symbol_min: 16'd448,
    half_symbol_max: 16'd832,
    full_symbol_min: 16'd896,
    full_symbol_max: 16'd1664
  };

  typedef struct packed {
    logic hw_sync;
    logic sw_sync;
    logic half_sym;
    logic full_sym;
  } pulse_cls_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  command_code;
    logic [15:0] rolling_count;
    logic [23:0] remote_address;
  } frame_chk_t;

endpackage : rpfd_pkg
`default_nettype wire

// ===== hw/rtl/rts_pulse_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rts_pulse_frame_decoder: rolling-code radio frame decoder
// Usage:
//   in channel  : one word per pulse (width in us, capture end mark),
//                 valid/ready.
//   out channel : at most one word per capture, either the decoded frame or
//                 a fail word on the last pulse, valid/ready.
//   cfg port    : write enable, index and data; the eight window bounds.
//                 Write only while the decoder is idle.
// Path: a taken word waits in the input register, is decoded from there and
//   its result, if any, is stored in the output register.
// Throughput: one pulse word per cycle while the output side takes words;
//   the decode is a single pass of compares and the checksum tree.
// Stall: a waiting result holds; the input register still takes one word,
//   then ready drops until the result is taken.
// Reset: decoder waits for sync, windows return to their defaults.
// ----------------------------------------------------------------------------
module rts_pulse_frame_decoder
  import rpfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire in_word_t           in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output out_word_t               out_data_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [PulseW-1:0]  cfg_data_i
);

  cfg_t      cfg_q;
  logic      in_valid_q;
  in_word_t  in_data_q;
  logic      out_valid_q;
  out_word_t out_data_q;
  logic      advance;
  logic      res_valid;
  out_word_t res;

  // a word leaves the input register only when the result register is free or being taken
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HW_SYNC_MIN:  cfg_q.hw_sync_min     <= cfg_data_i;
        CFG_HW_SYNC_MAX:  cfg_q.hw_sync_max     <= cfg_data_i;
        CFG_SW_SYNC_MIN:  cfg_q.sw_sync_min     <= cfg_data_i;
        CFG_SW_SYNC_MAX:  cfg_q.sw_sync_max     <= cfg_data_i;
        CFG_HALF_SYM_MIN: cfg_q.half_symbol_min <= cfg_data_i;
        CFG_HALF_SYM_MAX: cfg_q.half_symbol_max <= cfg_data_i;
        CFG_FULL_SYM_MIN: cfg_q.full_symbol_min <= cfg_data_i;
        CFG_FULL_SYM_MAX: cfg_q.full_symbol_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  rpfd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .word_i      (in_data_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule : rts_pulse_frame_decoder
`default_nettype wire

// ===== hw/rtl/rpfd_classify.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfd_classify: pulse width classifier
// Compares one pulse width against the four windows; both bounds are exclusive.
// ----------------------------------------------------------------------------
module rpfd_classify
  import rpfd_pkg::*;
(
  input  wire logic [PulseW-1:0] width_i,
  input  wire cfg_t              cfg_i,
  output pulse_cls_t             cls_o
);

  always_comb begin
    cls_o.hw_sync  = (width_i > cfg_i.hw_sync_min) && (width_i < cfg_i.hw_sync_max);
    cls_o.sw_sync  = (width_i > cfg_i.sw_sync_min) && (width_i < cfg_i.sw_sync_max);
    cls_o.half_sym = (width_i > cfg_i.half_symbol_min) && (width_i < cfg_i.half_symbol_max);
    cls_o.full_sym = (width_i > cfg_i.full_symbol_min) && (width_i < cfg_i.full_symbol_max);
  end

endmodule : rpfd_classify
`default_nettype wire

// ===== hw/rtl/rpfd_check.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfd_check: frame deobfuscation and checksum
// Undoes the XOR chain over bytes 1 to 6, checks the nibble checksums and
// extracts command, rolling code and remote address.
// ----------------------------------------------------------------------------
module rpfd_check
  import rpfd_pkg::*;
(
  input  wire logic [FrameW-1:0] frame_i,
  input  wire logic              long_mode_i,
  output frame_chk_t             chk_o
);

  logic [7:0] raw [NumBytes];
  logic [7:0] dec [NumBytes];
  logic [3:0] sum;
  logic [3:0] ext_sum;

  always_comb begin
    for (int k = 0; k < NumBytes; k++) begin
      raw[k] = frame_i[FrameW-1-8*k -: 8];
    end
    dec[0] = raw[0];
    for (int k = 1; k < 7; k++) begin
      dec[k] = raw[k] ^ raw[k-1];
    end
    for (int k = 7; k < NumBytes; k++) begin
      dec[k] = raw[k];
    end

    // byte 1 contributes only its high nibble; its low nibble is the checksum
    sum = dec[1][7:4];
    for (int k = 0; k < 7; k++) begin
      if (k != 1) begin
        sum = sum ^ dec[k][7:4] ^ dec[k][3:0];
      end
    end
    ext_sum = dec[7][7:4] ^ dec[8][7:4] ^ dec[9][7:4] ^ dec[7][3:0] ^ dec[8][3:0];

    chk_o.ok             = (sum == dec[1][3:0]) && (!long_mode_i || ext_sum == dec[9][3:0]);
    chk_o.command_code   = dec[1][7:4];
    chk_o.rolling_count  = {dec[2], dec[3]};
    chk_o.remote_address = {dec[4], dec[5], dec[6]};
  end

endmodule : rpfd_check
`default_nettype wire

// ===== hw/rtl/rpfd_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rpfd_core: sync tracking and bit decoding
// Holds the decoder state and works out the next state and the result for
// one pulse word in a single pass.
// ----------------------------------------------------------------------------
module rpfd_core
  import rpfd_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     step_i,
  input  wire in_word_t word_i,
  input  wire cfg_t     cfg_i,
  output logic          res_valid_o,
  output out_word_t     res_o
);

  typedef enum logic [2:0] {
    PH_WAIT = 3'b001,
    PH_RECV = 3'b010,
    PH_DONE = 3'b100
  } phase_e;

  typedef struct packed {
    phase_e              phase;
    logic [SyncCntW-1:0] sync_cnt;
    logic [BitCntW-1:0]  bits;
    logic                last_bit;
    logic                half_pend;
    logic                long_mode;
    logic [FrameW-1:0]   bytes;
  } state_t;

  localparam state_t StIdle = '{
    phase:     PH_WAIT,
    sync_cnt:  '0,
    bits:      '0,
    last_bit:  1'b0,
    half_pend: 1'b0,
    long_mode: 1'b0,
    bytes:     '0
  };

  localparam logic [SyncCntW-1:0] SyncMax   = '1;
  localparam logic [FrameW-1:0]   FirstBit  = {1'b1, {(FrameW-1){1'b0}}};
  localparam logic [BitCntW-1:0]  ShortLen  = BitCntW'(ShortBits);
  localparam logic [BitCntW-1:0]  LongLen   = BitCntW'(LongBits);
  localparam logic [SyncCntW-1:0] MinSyncs  = SyncCntW'(MinHwSyncs);

  state_t            st_q, st_d;
  pulse_cls_t        cls;
  frame_chk_t        chk;
  logic              put;
  logic              put_level;
  logic [FrameW-1:0] frame_nx;

  rpfd_classify u_classify (
    .width_i (word_i.pulse_width),
    .cfg_i   (cfg_i),
    .cls_o   (cls)
  );

  // level of the bit a symbol would complete, and the frame with that bit stored
  assign put_level = (cls.full_sym && !st_q.half_pend) ? ~st_q.last_bit : st_q.last_bit;
  assign frame_nx  = put_level ? (st_q.bytes | (FirstBit >> st_q.bits)) : st_q.bytes;

  rpfd_check u_check (
    .frame_i     (frame_nx),
    .long_mode_i (st_q.long_mode),
    .chk_o       (chk)
  );

  always_comb begin
    st_d        = st_q;
    put         = 1'b0;
    res_valid_o = 1'b0;
    res_o       = '0;

    unique case (st_q.phase)
      PH_WAIT: begin
        if (cls.hw_sync) begin
          if (st_q.sync_cnt != SyncMax) begin
            st_d.sync_cnt = st_q.sync_cnt + 1'b1;
          end
        end else if (cls.sw_sync && st_q.sync_cnt >= MinSyncs) begin
          st_d           = StIdle;
          st_d.sync_cnt  = st_q.sync_cnt;
          st_d.phase     = PH_RECV;
          st_d.long_mode = (st_q.sync_cnt == 5'd12) || (st_q.sync_cnt == 5'd13) ||
                           (st_q.sync_cnt > 5'd17);
        end else begin
          st_d.sync_cnt = '0;
        end
      end
      PH_RECV: begin
        if (cls.full_sym && !st_q.half_pend) begin
          st_d.last_bit = ~st_q.last_bit;
          put           = 1'b1;
        end else if (cls.half_sym) begin
          if (st_q.half_pend) begin
            st_d.half_pend = 1'b0;
            put            = 1'b1;
          end else begin
            st_d.half_pend = 1'b1;
          end
        end else begin
          // pulse out of range or full symbol after a half: drop the frame, count a fitting hw sync
          st_d          = StIdle;
          st_d.sync_cnt = cls.hw_sync ? 5'd1 : 5'd0;
        end

        if (put) begin
          st_d.bytes = frame_nx;
          st_d.bits  = st_q.bits + 1'b1;
        end

        if (put && st_d.bits >= (st_q.long_mode ? LongLen : ShortLen)) begin
          if (chk.ok) begin
            res_valid_o          = 1'b1;
            res_o.frame_found    = 1'b1;
            res_o.command_code   = chk.command_code;
            res_o.rolling_count  = chk.rolling_count;
            res_o.remote_address = chk.remote_address;
            st_d                 = StIdle;
            st_d.phase           = PH_DONE;
          end else begin
            st_d = StIdle;
          end
        end
      end
      PH_DONE: begin
        // rest of the capture ignored
      end
      default: begin
        st_d = StIdle;
      end
    endcase

    if (word_i.capture_end) begin
      if (!res_valid_o && st_d.phase != PH_DONE) begin
        res_valid_o = 1'b1;
        res_o       = '0;
      end
      st_d = StIdle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule : rpfd_core
`default_nettype wire
